// ----- rtl/core/mei_pkg.sv -----
// Shared types, codes and constants for the Mandelbrot escape iteration block.
package mei_pkg;

	localparam int COUNT_W = 11;
	localparam int SHADE_W = 4;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 11'd256;
	localparam int ESCAPE_MULT = 4;
	localparam int SHADE_TOP = 10;
	localparam int FIRST_THRESHOLD = 2;

	localparam logic REG_MAX_ITER = 1'b0;

	localparam logic [1:0] MUL_ZR_ZI = 2'd0;
	localparam logic [1:0] MUL_ZR_ZR = 2'd1;
	localparam logic [1:0] MUL_ZI_ZI = 2'd2;

	typedef struct packed {
		logic       load;
		logic [1:0] mul_sel;
		logic       upd_zr;
		logic       upd_zi;
		logic       upd_zr2;
		logic       upd_zi2;
		logic       finish;
	} mei_cmd_t;

	typedef struct packed {
		logic done;
	} mei_status_t;

	function automatic logic [SHADE_W-1:0] shade_of(input logic [31:0] count,
			input logic [31:0] limit);
		logic [SHADE_W-1:0] band;
		band = SHADE_W'(1);
		if (count >= limit) begin
			band = '0;
		end else begin
			for (int k = 0; k < SHADE_TOP - 1; k++) begin
				if (count > (32'(FIRST_THRESHOLD) << k)) begin
					band = band + SHADE_W'(1);
				end
			end
		end
		return band;
	endfunction

endpackage

// ----- rtl/core/mandelbrot_escape_iteration_top.sv -----
// Top level of the Mandelbrot escape iteration block with its configuration port.
//
// A point c (c_real, c_imag, signed fixed point) is transferred on the point
// channel when point_valid is high and point_stall is low. The block iterates
// z = z*z + c from zero until |z|^2 reaches 4.0 or the count reaches the
// limit held in register max_iterations (clamped to ITER_LIMIT_MAX, byte address 0, reset value 256).
// The result (iteration_count, shade_index) is transferred on the result
// channel when result_valid is high and result_stall is low.
// Each iteration steps through the states test, zi, zr2 and zi2, set by the
// single shared multiplier that forms zr*zi, zr*zr and zi*zi in turn. The next
// point can be transferred in the same cycle that the result first shows valid.
// Points are worked on one at a time.
// The result sits in an output register, so a new point is taken while an
// earlier result waits. If the receiver stalls, a finished point holds in
// the test step until the output register is free.
// Reset clears the controller and the result valid and sets max_iterations
// to 256. Write max_iterations only while the block is idle.
module mandelbrot_escape_iteration_top #(
	parameter int ITER_LIMIT_MAX = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mei_pkg::PADDR_W-1:0]   paddr,
	input  logic [mei_pkg::DATA_W-1:0]    pwdata,
	output logic [mei_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [31:0]            c_real,
	input  logic signed [31:0]            c_imag,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [mei_pkg::COUNT_W-1:0]   iteration_count,
	output logic [mei_pkg::SHADE_W-1:0]   shade_index
);
	import mei_pkg::*;

	logic [COUNT_W-1:0] max_iter_q;
	logic reg_sel;
	mei_cmd_t cmd;
	mei_status_t status;

	assign pready = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_MAX_ITER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_iter_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(DATA_W-COUNT_W){1'b0}}, max_iter_q} : '0;

	mei_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	mei_datapath #(
		.ITER_LIMIT_MAX (ITER_LIMIT_MAX),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_datapath (
		.clk             (clk),
		.cmd             (cmd),
		.status          (status),
		.max_iterations  (max_iter_q),
		.c_real          (c_real),
		.c_imag          (c_imag),
		.iteration_count (iteration_count),
		.shade_index     (shade_index)
	);

endmodule

// ----- rtl/core/mei_datapath.sv -----
// Datapath: point registers, shared fixed-point multiplier, counter and result register.
module mei_datapath #(
	parameter int ITER_LIMIT_MAX = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  mei_pkg::mei_cmd_t            cmd,
	output mei_pkg::mei_status_t         status,
	input  logic [mei_pkg::COUNT_W-1:0]  max_iterations,
	input  logic signed [31:0]           c_real,
	input  logic signed [31:0]           c_imag,
	output logic [mei_pkg::COUNT_W-1:0]  iteration_count,
	output logic [mei_pkg::SHADE_W-1:0]  shade_index
);
	import mei_pkg::*;

	localparam int LIMIT_W = $clog2(ITER_LIMIT_MAX + 1);
	localparam logic [31:0] ESC_BOUND = 32'(ESCAPE_MULT) << FRACTION_BITS;

	logic signed [31:0] cr_q, ci_q, zr_q, zi_q, zr2_q, zi2_q, p_q;
	logic [LIMIT_W-1:0] count_q, limit_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic [31:0] mag, limit_sel, cnt32, lim32;

	always_comb begin
		case (cmd.mul_sel)
			MUL_ZR_ZR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			MUL_ZI_ZI: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign mag = zr2_q + zi2_q;
	assign cnt32 = 32'(count_q);
	assign lim32 = 32'(limit_q);
	assign limit_sel = ({21'b0, max_iterations} > 32'(ITER_LIMIT_MAX)) ?
		32'(ITER_LIMIT_MAX) : {21'b0, max_iterations};
	assign status.done = (count_q >= limit_q) || (!mag[31] && (mag >= ESC_BOUND));

	always_ff @(posedge clk) begin
		p_q <= prod[FRACTION_BITS+31:FRACTION_BITS];
		if (cmd.load) begin
			cr_q <= c_real;
			ci_q <= c_imag;
			zr_q <= '0;
			zi_q <= '0;
			zr2_q <= '0;
			zi2_q <= '0;
			count_q <= '0;
			limit_q <= limit_sel[LIMIT_W-1:0];
		end else begin
			if (cmd.upd_zr) begin
				zr_q <= zr2_q - zi2_q + cr_q;
			end
			if (cmd.upd_zi) begin
				zi_q <= {p_q[30:0], 1'b0} + ci_q;
			end
			if (cmd.upd_zr2) begin
				zr2_q <= p_q;
			end
			if (cmd.upd_zi2) begin
				zi2_q <= p_q;
				count_q <= count_q + LIMIT_W'(1);
			end
		end
		if (cmd.finish) begin
			iteration_count <= cnt32[COUNT_W-1:0];
			shade_index <= shade_of(cnt32, lim32);
		end
	end

endmodule

// ----- rtl/core/mei_ctrl.sv -----
// Controller: state machine that sequences the four phases of each iteration.
module mei_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	output logic                  point_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  mei_pkg::mei_status_t  status,
	output mei_pkg::mei_cmd_t     cmd
);
	import mei_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TEST = 3'd1;
	localparam logic [2:0] ST_ZI   = 3'd2;
	localparam logic [2:0] ST_ZR2  = 3'd3;
	localparam logic [2:0] ST_ZI2  = 3'd4;

	logic [2:0] state_q, state_d;
	logic valid_q;
	logic out_free;

	assign point_stall = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign out_free = !(valid_q && result_stall);

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_ZR_ZI;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					cmd.load = 1'b1;
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (status.done) begin
					if (out_free) begin
						cmd.finish = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.mul_sel = MUL_ZR_ZI;
					cmd.upd_zr = 1'b1;
					state_d = ST_ZI;
				end
			end
			ST_ZI: begin
				cmd.mul_sel = MUL_ZR_ZR;
				cmd.upd_zi = 1'b1;
				state_d = ST_ZR2;
			end
			ST_ZR2: begin
				cmd.mul_sel = MUL_ZI_ZI;
				cmd.upd_zr2 = 1'b1;
				state_d = ST_ZI2;
			end
			ST_ZI2: begin
				cmd.upd_zi2 = 1'b1;
				state_d = ST_TEST;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
